[sv/multi_pattern_match_counter_macros.svh]
// assertion helpers for the multi-pattern match counter
`ifndef MULTI_PATTERN_MATCH_COUNTER_MACROS_SVH
`define MULTI_PATTERN_MATCH_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MPMC_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpmc assertion failed");
// next-cycle implication
`define MPMC_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpmc assertion failed");
`else
`define MPMC_AST_IMP(lbl, clk, rst_n, ante, cons)
`define MPMC_AST_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/mpmc_pkg.sv]
`timescale 1ns / 1ps
package mpmc_pkg;
    localparam int OP_W     = 3;
    localparam int LETTER_W = 5;
    localparam int COUNT_W  = 16;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_PATTERN = 3'd0,
        OP_END     = 3'd1,
        OP_BUILD   = 3'd2,
        OP_TEXT    = 3'd3,
        OP_FINISH  = 3'd4
    } t_op;

    // child table access request
    typedef struct packed {
        logic rd;
        logic wr;
    } t_ct_req;

    // per-node marks
    typedef struct packed {
        logic reached;
        logic counted;
    } t_mark;
endpackage

[sv/mpmc_in_if.sv]
`timescale 1ns / 1ps
interface mpmc_in_if import mpmc_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output operation, output letter, input ready);
    modport sink (input valid, input operation, input letter, output ready);
endinterface

[sv/mpmc_out_if.sv]
`timescale 1ns / 1ps
interface mpmc_out_if import mpmc_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic               status;

    modport source (output valid, output match_count, output status, input ready);
    modport sink (input valid, input match_count, input status, output ready);
endinterface

[sv/mpmc_sat_add.sv]
`timescale 1ns / 1ps
module mpmc_sat_add import mpmc_pkg::*; (
    input  logic [COUNT_W-1:0] i_a,
    input  logic [COUNT_W-1:0] i_b,
    output logic [COUNT_W-1:0] o_sum
);
    logic [COUNT_W:0] sum_w;

    always_comb begin
        sum_w = {1'b0, i_a} + {1'b0, i_b};
        o_sum = sum_w[COUNT_W] ? COUNT_LIMIT : sum_w[COUNT_W-1:0];
    end
endmodule

[sv/mpmc_child_table.sv]
`timescale 1ns / 1ps
module mpmc_child_table import mpmc_pkg::*; #(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ct_req                          i_req,
    input  logic [$clog2(MAX_NODES)-1:0]     i_node,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] i_sym,
    input  logic [$clog2(MAX_NODES)-1:0]     i_wdata,
    output logic [$clog2(MAX_NODES)-1:0]     o_rdata,
    output logic                             o_busy
);
    localparam int NW    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [NW-1:0] r_mem [DEPTH];
    logic [NW-1:0] r_rdata;
    logic [AW-1:0] r_clr;
    logic          r_busy;
    logic [AW-1:0] addr;

    // row-major: node times alphabet plus letter
    assign addr    = AW'(i_node) * AW'(ALPHABET_SIZE) + AW'(i_sym);
    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    // zero sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + AW'(1);
            if (r_clr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_req.wr) begin
            r_mem[addr] <= i_wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[addr];
        end
    end
endmodule

[sv/multi_pattern_match_counter.sv]
`timescale 1ns / 1ps
// Aho-Corasick match counter over a letter alphabet. Beats with operation 0
// grow the trie one letter at a time, operation 1 ends and counts a pattern,
// operation 2 builds failure links breadth-first, operation 3 scans a text
// letter and operation 4 returns the total (saturating at 65535) with the
// overflow status as one output beat. One beat is handled at a time; ready
// is low while it is worked on. Every step is bounded by the single-port
// child table, read once per cycle with registered data. A pattern letter
// or a text letter with a direct transition is a table read and a check,
// an end a count read and write; each failure hop of a text letter adds a
// failure-link read. A dropped pattern letter or end, an out-of-alphabet
// text letter and an unused code are handled in the idle state. A build
// reads each table entry of the root and of every queued node, pops each
// node and follows failure hops to link each non-root child. A finish walks
// the failure chain of each reached node, clears the marks of every node in
// use and waits on the output. After reset the child table is cleared entry
// by entry with ready held low.
`include "multi_pattern_match_counter_macros.svh"
module multi_pattern_match_counter import mpmc_pkg::*; #(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpmc_in_if.sink   i_in,
    mpmc_out_if.source o_out
);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int SYW = $clog2(ALPHABET_SIZE);

    typedef enum logic [4:0] {
        S_IDLE,
        S_PAT_RD, S_PAT_CHK,
        S_END_RD, S_END_WR,
        S_B_CRD, S_B_CCHK, S_B_GRD, S_B_GCHK, S_B_FW, S_B_POP, S_B_PW, S_B_PL,
        S_T_RD, S_T_CHK, S_T_FW,
        S_F_RD, S_F_CHK, S_F_WRD, S_F_WCHK, S_F_CLR, S_F_EMIT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_nodes;   // nodes in use, root included
    logic [NW-1:0]      r_ins;     // insert cursor
    logic [NW-1:0]      r_scan;    // scan cursor
    logic               r_ovf;
    logic               r_drop;    // current pattern discarded
    logic [COUNT_W-1:0] r_total;
    logic [SYW-1:0]     r_sym;
    // build walk
    logic [CW-1:0]      r_head;
    logic [CW-1:0]      r_tail;
    logic [NW-1:0]      r_p;
    logic [NW-1:0]      r_fp;
    logic [NW-1:0]      r_f;
    logic [NW-1:0]      r_c;
    logic               r_root;
    // text hop guard and finish sweep
    logic [CW-1:0]      r_guard;
    logic [CW-1:0]      r_n;
    logic [NW-1:0]      r_walk;
    // output register
    logic               r_ov;
    logic [COUNT_W-1:0] r_oc;
    logic               r_os;

    // node memories
    logic [NW-1:0]      r_fail_mem [MAX_NODES];
    logic [COUNT_W-1:0] r_cnt_mem  [MAX_NODES];
    t_mark              r_mark_mem [MAX_NODES];
    logic [NW-1:0]      r_que_mem  [MAX_NODES];
    logic [NW-1:0]      r_fail_q;
    logic [COUNT_W-1:0] r_cnt_q;
    t_mark              r_mark_q;
    logic [NW-1:0]      r_que_q;

    logic               fail_rd, fail_wr, cnt_rd, cnt_wr, mark_rd, mark_wr, que_rd, que_wr;
    logic [NW-1:0]      fail_a, cnt_a, mark_a, que_a;
    logic [NW-1:0]      fail_wd, que_wd;
    logic [COUNT_W-1:0] cnt_wd;
    t_mark              mark_wd;

    t_ct_req            ct_req;
    logic [NW-1:0]      ct_node;
    logic [SYW-1:0]     ct_sym;
    logic [NW-1:0]      ct_wdata;
    logic [NW-1:0]      ct_q;
    logic               ct_busy;

    logic [COUNT_W-1:0] add_a, add_b, add_sum;

    logic               accept;
    logic               nodes_full;
    logic               sym_ok;
    logic [8:0]         letter_w;
    logic               sym_last;

    mpmc_child_table #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_ct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ct_req),
        .i_node  (ct_node),
        .i_sym   (ct_sym),
        .i_wdata (ct_wdata),
        .o_rdata (ct_q),
        .o_busy  (ct_busy)
    );

    // shared saturating adder: pattern increments and the running total
    mpmc_sat_add u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    assign i_in.ready        = (r_state == S_IDLE) && !ct_busy;
    assign accept            = i_in.valid && i_in.ready;
    assign o_out.valid       = r_ov;
    assign o_out.match_count = r_oc;
    assign o_out.status      = r_os;

    assign nodes_full = (r_nodes == CW'(MAX_NODES));
    assign letter_w   = 9'(i_in.letter);
    assign sym_ok     = (letter_w < 9'(ALPHABET_SIZE));
    assign sym_last   = (r_sym == SYW'(ALPHABET_SIZE - 1));

    // memory port control, decoded from state and registered read data
    always_comb begin
        ct_req   = '0;
        ct_node  = r_ins;
        ct_sym   = r_sym;
        ct_wdata = r_nodes[NW-1:0];
        fail_rd  = 1'b0;
        fail_wr  = 1'b0;
        fail_a   = r_walk;
        fail_wd  = ct_q;
        cnt_rd   = 1'b0;
        cnt_wr   = 1'b0;
        cnt_a    = r_walk;
        cnt_wd   = add_sum;
        mark_rd  = 1'b0;
        mark_wr  = 1'b0;
        mark_a   = r_walk;
        mark_wd  = '0;
        que_rd   = 1'b0;
        que_wr   = 1'b0;
        que_a    = r_tail[NW-1:0];
        que_wd   = ct_q;
        add_a    = r_total;
        add_b    = r_cnt_q;
        unique case (r_state)
            S_PAT_RD: begin
                ct_req.rd = 1'b1;
            end
            S_PAT_CHK: begin
                // new node: link it in and give it a clean count and marks
                if (ct_q == '0 && !nodes_full) begin
                    ct_req.wr = 1'b1;
                    cnt_wr    = 1'b1;
                    cnt_a     = r_nodes[NW-1:0];
                    cnt_wd    = '0;
                    mark_wr   = 1'b1;
                    mark_a    = r_nodes[NW-1:0];
                end
            end
            S_END_RD: begin
                cnt_rd = 1'b1;
                cnt_a  = r_ins;
            end
            S_END_WR: begin
                add_a  = r_cnt_q;
                add_b  = COUNT_W'(1);
                cnt_wr = 1'b1;
                cnt_a  = r_ins;
            end
            S_B_CRD: begin
                ct_req.rd = 1'b1;
                ct_node   = r_p;
            end
            S_B_CCHK: begin
                // children of the root fail to the root
                if (ct_q != '0 && r_root) begin
                    fail_wr = 1'b1;
                    fail_a  = ct_q;
                    fail_wd = '0;
                    que_wr  = 1'b1;
                end
            end
            S_B_GRD: begin
                ct_req.rd = 1'b1;
                ct_node   = r_f;
            end
            S_B_GCHK: begin
                // found a goto, or fell to the root with none: target is ct_q
                if (ct_q != '0 || r_f == '0) begin
                    fail_wr = 1'b1;
                    fail_a  = r_c;
                    que_wr  = 1'b1;
                    que_wd  = r_c;
                end else begin
                    fail_rd = 1'b1;
                    fail_a  = r_f;
                end
            end
            S_B_POP: begin
                if (r_head != r_tail) begin
                    que_rd = 1'b1;
                    que_a  = r_head[NW-1:0];
                end
            end
            S_B_PW: begin
                fail_rd = 1'b1;
                fail_a  = r_que_q;
            end
            S_T_RD: begin
                ct_req.rd = 1'b1;
                ct_node   = r_scan;
            end
            S_T_CHK: begin
                if (ct_q != '0) begin
                    mark_wr         = 1'b1;
                    mark_a          = ct_q;
                    mark_wd.reached = 1'b1;
                end else if (r_scan != '0 && r_guard != CW'(MAX_NODES)) begin
                    fail_rd = 1'b1;
                    fail_a  = r_scan;
                end
            end
            S_F_RD: begin
                if (r_n < r_nodes) begin
                    mark_rd = 1'b1;
                    mark_a  = r_n[NW-1:0];
                end
            end
            S_F_WRD: begin
                mark_rd = 1'b1;
                cnt_rd  = 1'b1;
                fail_rd = 1'b1;
            end
            S_F_WCHK: begin
                if (!r_mark_q.counted) begin
                    mark_wr         = 1'b1;
                    mark_wd.reached = r_mark_q.reached;
                    mark_wd.counted = 1'b1;
                end
            end
            S_F_CLR: begin
                mark_wr = 1'b1;
                mark_a  = r_n[NW-1:0];
            end
            default: begin
            end
        endcase
    end

    // node memories, registered reads
    always_ff @(posedge i_clk) begin
        if (fail_wr) begin
            r_fail_mem[fail_a] <= fail_wd;
        end
        if (fail_rd) begin
            r_fail_q <= r_fail_mem[fail_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_wr) begin
            r_cnt_mem[cnt_a] <= cnt_wd;
        end
        if (cnt_rd) begin
            r_cnt_q <= r_cnt_mem[cnt_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_wr) begin
            r_mark_mem[mark_a] <= mark_wd;
        end
        if (mark_rd) begin
            r_mark_q <= r_mark_mem[mark_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (que_wr) begin
            r_que_mem[que_a] <= que_wd;
        end
        if (que_rd) begin
            r_que_q <= r_que_mem[que_a];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nodes <= CW'(1);
            r_ins   <= '0;
            r_scan  <= '0;
            r_ovf   <= 1'b0;
            r_drop  <= 1'b0;
            r_total <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // emit state reloads the output register itself
            if (r_ov && o_out.ready && r_state != S_F_EMIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (t_op'(i_in.operation))
                            OP_PATTERN: begin
                                if (!r_drop) begin
                                    if (!sym_ok) begin
                                        // letter outside the alphabet can never match
                                        r_drop <= 1'b1;
                                    end else begin
                                        r_sym   <= letter_w[SYW-1:0];
                                        r_state <= S_PAT_RD;
                                    end
                                end
                            end
                            OP_END: begin
                                if (r_drop) begin
                                    r_ins  <= '0;
                                    r_drop <= 1'b0;
                                end else begin
                                    r_state <= S_END_RD;
                                end
                            end
                            OP_BUILD: begin
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_p     <= '0;
                                r_root  <= 1'b1;
                                r_sym   <= '0;
                                r_state <= S_B_CRD;
                            end
                            OP_TEXT: begin
                                if (!sym_ok) begin
                                    // no transitions anywhere: back to the root
                                    r_scan <= '0;
                                end else begin
                                    r_sym   <= letter_w[SYW-1:0];
                                    r_guard <= '0;
                                    r_state <= S_T_RD;
                                end
                            end
                            OP_FINISH: begin
                                r_n     <= CW'(1);
                                r_state <= S_F_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PAT_RD: begin
                    r_state <= S_PAT_CHK;
                end
                S_PAT_CHK: begin
                    r_state <= S_IDLE;
                    if (ct_q != '0) begin
                        r_ins <= ct_q;
                    end else if (nodes_full) begin
                        r_ovf  <= 1'b1;
                        r_drop <= 1'b1;
                    end else begin
                        r_ins   <= r_nodes[NW-1:0];
                        r_nodes <= r_nodes + CW'(1);
                    end
                end
                S_END_RD: begin
                    r_state <= S_END_WR;
                end
                S_END_WR: begin
                    r_ins   <= '0;
                    r_drop  <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_B_CRD: begin
                    r_state <= S_B_CCHK;
                end
                S_B_CCHK: begin
                    if (ct_q != '0 && !r_root) begin
                        r_c     <= ct_q;
                        r_f     <= r_fp;
                        r_state <= S_B_GRD;
                    end else begin
                        if (ct_q != '0) begin
                            r_tail <= r_tail + CW'(1);
                        end
                        if (sym_last) begin
                            r_state <= S_B_POP;
                        end else begin
                            r_sym   <= r_sym + SYW'(1);
                            r_state <= S_B_CRD;
                        end
                    end
                end
                S_B_GRD: begin
                    r_state <= S_B_GCHK;
                end
                S_B_GCHK: begin
                    if (ct_q != '0 || r_f == '0) begin
                        r_tail <= r_tail + CW'(1);
                        if (sym_last) begin
                            r_state <= S_B_POP;
                        end else begin
                            r_sym   <= r_sym + SYW'(1);
                            r_state <= S_B_CRD;
                        end
                    end else begin
                        r_state <= S_B_FW;
                    end
                end
                S_B_FW: begin
                    r_f     <= r_fail_q;
                    r_state <= S_B_GRD;
                end
                S_B_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_B_PW;
                    end
                end
                S_B_PW: begin
                    r_p     <= r_que_q;
                    r_head  <= r_head + CW'(1);
                    r_state <= S_B_PL;
                end
                S_B_PL: begin
                    r_fp    <= r_fail_q;
                    r_root  <= 1'b0;
                    r_sym   <= '0;
                    r_state <= S_B_CRD;
                end
                S_T_RD: begin
                    r_state <= S_T_CHK;
                end
                S_T_CHK: begin
                    if (ct_q != '0) begin
                        r_scan  <= ct_q;
                        r_state <= S_IDLE;
                    end else if (r_scan == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_guard == CW'(MAX_NODES)) begin
                        r_scan  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_guard <= r_guard + CW'(1);
                        r_state <= S_T_FW;
                    end
                end
                S_T_FW: begin
                    r_scan  <= r_fail_q;
                    r_state <= S_T_RD;
                end
                S_F_RD: begin
                    if (r_n < r_nodes) begin
                        r_state <= S_F_CHK;
                    end else begin
                        r_n     <= '0;
                        r_state <= S_F_CLR;
                    end
                end
                S_F_CHK: begin
                    if (r_mark_q.reached) begin
                        r_walk  <= r_n[NW-1:0];
                        r_state <= S_F_WRD;
                    end else begin
                        r_n     <= r_n + CW'(1);
                        r_state <= S_F_RD;
                    end
                end
                S_F_WRD: begin
                    r_state <= S_F_WCHK;
                end
                S_F_WCHK: begin
                    // stop at a counted node or at the root
                    if (r_mark_q.counted) begin
                        r_n     <= r_n + CW'(1);
                        r_state <= S_F_RD;
                    end else begin
                        r_total <= add_sum;
                        if (r_fail_q == '0) begin
                            r_n     <= r_n + CW'(1);
                            r_state <= S_F_RD;
                        end else begin
                            r_walk  <= r_fail_q;
                            r_state <= S_F_WRD;
                        end
                    end
                end
                S_F_CLR: begin
                    if (r_n + CW'(1) == r_nodes) begin
                        r_state <= S_F_EMIT;
                    end else begin
                        r_n <= r_n + CW'(1);
                    end
                end
                S_F_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_oc    <= r_total;
                        r_os    <= r_ovf;
                        r_total <= '0;
                        r_scan  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MPMC_AST_IMP(a_nodes_bound, i_clk, i_rst_n, 1'b1, r_nodes <= CW'(MAX_NODES))
    `MPMC_AST_IMP(a_ins_exists, i_clk, i_rst_n, 1'b1, CW'(r_ins) < r_nodes)
    `MPMC_AST_NXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf)
    `MPMC_AST_IMP(a_queue_order, i_clk, i_rst_n, 1'b1, r_head <= r_tail)
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import mpmc_pkg::*;

    localparam int NODES     = 1024;
    localparam int SYMS      = 26;
    localparam int STALL_MAX = 400000;
    localparam int DRAIN_GAP = 300;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic               status;
    } t_total;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [LETTER_W-1:0] ltr;
        bit                  typed;
        t_total              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mpmc_in_if  in_bus ();
    mpmc_out_if out_bus ();

    multi_pattern_match_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // trie mirror
    logic [9:0]         trie_kid [NODES*SYMS];
    logic [9:0]         fail_to [NODES];
    logic [COUNT_W-1:0] hits_at [NODES];
    bit                 seen [NODES];
    bit                 tallied [NODES];
    int                 node_cnt;
    int                 ins_at;
    int                 scan_at;
    bit                 table_full;
    bit                 dropping;
    int                 running_total;
    bit                 links_stale;

    t_total pending_totals[$];
    int     errors;
    int     beats_sent;
    bit     calm;
    int     stall_cycles;

    function automatic int kid_of(int n, int s);
        if (n >= NODES || s >= SYMS) return 0;
        return int'(trie_kid[n*SYMS+s]);
    endfunction

    function automatic void trie_add_letter(int s);
        int nxt;
        if (dropping) return;
        if (s >= SYMS) begin
            dropping = 1;
            return;
        end
        nxt = kid_of(ins_at, s);
        if (nxt == 0) begin
            if (node_cnt >= NODES) begin
                table_full = 1;
                dropping   = 1;
                return;
            end
            nxt = node_cnt;
            node_cnt++;
            trie_kid[ins_at*SYMS+s] = nxt[9:0];
            links_stale = 1;
        end
        ins_at = nxt;
    endfunction

    function automatic void trie_close_pattern();
        if (!dropping && hits_at[ins_at] != COUNT_LIMIT)
            hits_at[ins_at] = hits_at[ins_at] + 1'b1;
        ins_at   = 0;
        dropping = 0;
    endfunction

    // breadth-first failure links
    function automatic void trie_link_build();
        int order[$];
        int p, c, f, g, tgt;
        fail_to[0] = '0;
        for (int s = 0; s < SYMS; s++) begin
            c = kid_of(0, s);
            if (c != 0) begin
                fail_to[c] = '0;
                order.push_back(c);
            end
        end
        while (order.size() > 0) begin
            p = order.pop_front();
            for (int s = 0; s < SYMS; s++) begin
                c = kid_of(p, s);
                if (c == 0) continue;
                f   = int'(fail_to[p]);
                tgt = 0;
                for (int k = 0; k <= NODES; k++) begin
                    g = kid_of(f, s);
                    if (g != 0) begin
                        tgt = g;
                        break;
                    end
                    if (f == 0) break;
                    f = int'(fail_to[f]);
                end
                fail_to[c] = tgt[9:0];
                order.push_back(c);
            end
        end
        links_stale = 0;
    endfunction

    function automatic void scan_letter(int s);
        for (int k = 0; k <= NODES; k++) begin
            if (scan_at == 0 || kid_of(scan_at, s) != 0) break;
            scan_at = int'(fail_to[scan_at]);
        end
        if (kid_of(scan_at, s) != 0) begin
            scan_at       = kid_of(scan_at, s);
            seen[scan_at] = 1;
        end else begin
            scan_at = 0;
        end
    endfunction

    // every reached node and its failure ancestors, each counted once
    function automatic t_total harvest_total();
        t_total r;
        int w;
        for (int n = 1; n < node_cnt; n++) begin
            if (!seen[n]) continue;
            w = n;
            for (int k = 0; k <= NODES; k++) begin
                if (w == 0 || tallied[w]) break;
                tallied[w] = 1;
                running_total += int'(hits_at[w]);
                if (running_total > 65535) running_total = 65535;
                w = int'(fail_to[w]);
            end
        end
        r.total  = running_total[COUNT_W-1:0];
        r.status = table_full;
        for (int n = 0; n < NODES; n++) begin
            seen[n]    = 0;
            tallied[n] = 0;
        end
        running_total = 0;
        scan_at       = 0;
        return r;
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input bit typed, input t_total want);
        t_total got;
        if (!calm && $urandom_range(99) < 19) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.letter    <= ltr;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        beats_sent++;
        case (op)
            OP_PATTERN: trie_add_letter(int'(ltr));
            OP_END:     trie_close_pattern();
            OP_BUILD:   trie_link_build();
            OP_TEXT:    scan_letter(int'(ltr));
            OP_FINISH: begin
                got = harvest_total();
                pending_totals.push_back(typed ? want : got);
            end
            default: ;
        endcase
    endtask

    // text only runs over links that cover the whole trie
    task automatic feed(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr);
        if (op == OP_TEXT && links_stale) send_beat(OP_BUILD, '0, 0, '0);
        send_beat(op, ltr, 0, '0);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_totals.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [LETTER_W-1:0] pick_letter(int span);
        if ($urandom_range(29) == 0) return LETTER_W'($urandom_range(26, 31));
        return LETTER_W'($urandom_range(0, span));
    endfunction

    task automatic run_session();
        int span;
        span = ($urandom_range(3) == 0) ? 25 : 3;
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 5)) begin
                feed(OP_PATTERN, pick_letter(span));
                if ($urandom_range(14) == 0) feed(OP_BUILD, LETTER_W'($urandom));
            end
            feed(OP_END, LETTER_W'($urandom));
        end
        if ($urandom_range(4) != 0) feed(OP_BUILD, LETTER_W'($urandom));
        repeat ($urandom_range(1, 15)) begin
            if ($urandom_range(19) == 0)
                feed(OP_SPARE_A + OP_W'($urandom_range(0, 2)), LETTER_W'($urandom));
            feed(OP_TEXT, pick_letter(span));
        end
        feed(OP_FINISH, LETTER_W'($urandom));
    endtask

    t_row directed[] = '{
        '{OP_FINISH,  5'd0,  1, '{16'd0, 1'b0}},   // empty trie, nothing scanned
        '{OP_PATTERN, 5'd0,  0, '0},                 // "a"
        '{OP_END,     5'd0,  0, '0},
        '{OP_PATTERN, 5'd0,  0, '0},                 // "ab"
        '{OP_PATTERN, 5'd1,  0, '0},
        '{OP_END,     5'd0,  0, '0},
        '{OP_PATTERN, 5'd25, 0, '0},                 // "z"
        '{OP_END,     5'd31, 0, '0},
        '{OP_END,     5'd0,  0, '0},                 // empty pattern counts at root
        '{OP_PATTERN, 5'd0,  0, '0},                 // letter outside alphabet drops it
        '{OP_PATTERN, 5'd31, 0, '0},
        '{OP_PATTERN, 5'd1,  0, '0},
        '{OP_END,     5'd0,  0, '0},
        '{OP_BUILD,   5'd0,  0, '0},
        '{OP_TEXT,    5'd0,  0, '0},
        '{OP_TEXT,    5'd1,  0, '0},
        '{OP_TEXT,    5'd25, 0, '0},
        '{OP_TEXT,    5'd31, 0, '0},                 // falls back to root
        '{OP_TEXT,    5'd0,  0, '0},
        '{OP_SPARE_A, 5'd31, 0, '0},                 // unused codes are ignored
        '{OP_SPARE_B, 5'd0,  0, '0},
        '{OP_SPARE_C, 5'd21, 0, '0},
        '{OP_FINISH,  5'd0,  1, '{16'd3, 1'b0}},   // a, ab and z once each
        '{OP_FINISH,  5'd0,  1, '{16'd0, 1'b0}}    // marks were cleared
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side stalls at the same rate as the sender idles
    always @(posedge i_clk) begin
        out_bus.ready <= calm || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        if (out_bus.valid && out_bus.ready) begin
            if (pending_totals.size() == 0) begin
                $display("%0t: unexpected result beat count=%0d status=%0d",
                         $time, out_bus.match_count, out_bus.status);
                errors++;
            end else begin
                t_total w;
                w = pending_totals.pop_front();
                if (out_bus.match_count !== w.total) begin
                    $display("%0t: match_count expected %0d actual %0d",
                             $time, w.total, out_bus.match_count);
                    errors++;
                end
                if (out_bus.status !== w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.status, out_bus.status);
                    errors++;
                end
            end
        end
    end

    // long silences cover the table clear and a full build; beyond that it hangs
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("multi_pattern_match_counter verification failed");
            $finish;
        end
    end

    initial begin
        in_bus.valid     = 1'b0;
        in_bus.operation = OP_PATTERN;
        in_bus.letter    = '0;
        i_rst_n          = 1'b0;
        errors           = 0;
        beats_sent       = 0;
        calm             = 0;
        node_cnt         = 1;
        ins_at           = 0;
        scan_at          = 0;
        table_full       = 0;
        dropping         = 0;
        running_total    = 0;
        links_stale      = 1;
        for (int i = 0; i < NODES*SYMS; i++) trie_kid[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            fail_to[i] = '0;
            hits_at[i] = '0;
            seen[i]    = 0;
            tallied[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].op, directed[i].ltr, directed[i].typed, directed[i].want);

        // well-formed sessions mixed with loose noise
        while (beats_sent < 850) begin
            calm = (beats_sent >= 350 && beats_sent < 550);
            if ($urandom_range(99) < 80) begin
                run_session();
                if ($urandom_range(9) == 0) drain();
            end else begin
                repeat ($urandom_range(1, 6))
                    feed(OP_W'($urandom_range(0, 7)), LETTER_W'($urandom));
            end
        end
        calm = 0;
        drain();

        // fill the node table until it overflows, then match on the full trie
        while (!table_full) begin
            repeat (10) feed(OP_PATTERN, LETTER_W'($urandom_range(0, 25)));
            feed(OP_END, '0);
        end
        repeat (4) feed(OP_PATTERN, LETTER_W'($urandom_range(0, 25)));
        feed(OP_END, '0);
        feed(OP_BUILD, '0);
        repeat (30) feed(OP_TEXT, LETTER_W'($urandom_range(0, 25)));
        feed(OP_FINISH, '0);
        feed(OP_FINISH, '0);

        drain();
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (errors == 0) begin
            $display("multi_pattern_match_counter verification clean");
        end else begin
            $display("multi_pattern_match_counter verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/mpmc_pkg.sv
sv/mpmc_in_if.sv
sv/mpmc_out_if.sv
sv/mpmc_sat_add.sv
sv/mpmc_child_table.sv
sv/multi_pattern_match_counter.sv
tb/testbench.sv
